FILE: rtl/core/sipq_pkg.sv
// shared types and constants of the sorted-insertion priority queue
package sipq_pkg;

  localparam int DEPTH_DEFAULT     = 16;
  localparam int KEY_WIDTH_DEFAULT = 32;
  localparam int VALUE_W           = 32;
  localparam int COUNT_W           = 5;

  localparam logic signed [VALUE_W-1:0] UNDERFLOW_VALUE = -32'sd1;

  typedef enum logic {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_t;

  // shift controls broadcast to every cell
  typedef struct packed {
    logic enq;
    logic deq;
  } op_t;

endpackage

FILE: rtl/core/sipq_cell.sv
// one storage cell of the sorted key row
module sipq_cell #(
  parameter int KEY_WIDTH = sipq_pkg::KEY_WIDTH_DEFAULT
) (
  input  logic                        clk,
  input  sipq_pkg::op_t               op,
  input  logic                        occupied,
  input  logic signed [KEY_WIDTH-1:0] new_key,
  input  logic signed [KEY_WIDTH-1:0] left_key,
  input  logic                        left_greater,
  input  logic signed [KEY_WIDTH-1:0] right_key,
  output logic                        greater,
  output logic signed [KEY_WIDTH-1:0] key
);

  logic signed [KEY_WIDTH-1:0] key_next;

  // strictly greater, so equal keys stay ahead of the new one
  assign greater = occupied && (key > new_key);

  always_comb begin
    key_next = key;
    if (op.enq) begin
      if (left_greater) begin
        key_next = left_key;
      end else if (greater || !occupied) begin
        key_next = new_key;
      end
    end else if (op.deq) begin
      key_next = right_key;
    end
  end

  always_ff @(posedge clk) begin
    key <= key_next;
  end

endmodule

FILE: rtl/core/sorted_insert_min_priority_queue.sv
// top level of the sorted-insertion min priority queue
//
// a bounded min priority queue held as a row of DEPTH cells in ascending order
// command channel: a transaction is taken at a rising edge with start high and
//   busy low; cmd selects enqueue of value or dequeue of the smallest key
// busy stays low: every cell compares its key with the new one in parallel and
//   shifts in the same cycle, so one operation is taken every clock cycle
// result channel: done is high for exactly one cycle, the cycle after the
//   command was taken; out_value, status and count are valid then
// out_value is the dequeued key, -1 on underflow, 0 on any enqueue
// status: ok, underflow (dequeue while empty), overflow (enqueue while full,
//   key dropped); an underflow or overflow leaves the queue unchanged
// count reports the number of stored entries after the operation
// equal keys leave in arrival order
// the receiver cannot stall; each result must be taken in its one cycle
// reset (rst, synchronous) empties the queue and clears done; cell contents
//   are left as they are and only occupied cells are ever read
module sorted_insert_min_priority_queue #(
  parameter int DEPTH     = sipq_pkg::DEPTH_DEFAULT,
  parameter int KEY_WIDTH = sipq_pkg::KEY_WIDTH_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 cmd,
  input  logic signed [sipq_pkg::VALUE_W-1:0]  value,
  output logic                                 done,
  output logic signed [sipq_pkg::VALUE_W-1:0]  out_value,
  output logic [1:0]                           status,
  output logic [sipq_pkg::COUNT_W-1:0]         count
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic                        accept;
  logic                        full;
  logic                        empty;
  sipq_pkg::op_t               op;
  logic signed [KEY_WIDTH-1:0] new_key;
  logic signed [KEY_WIDTH-1:0] cell_key [DEPTH];
  logic [DEPTH-1:0]            greater;
  logic [CNT_W-1:0]            entry_count;
  logic [CNT_W-1:0]            entry_count_next;
  logic signed [sipq_pkg::VALUE_W-1:0] out_value_next;
  sipq_pkg::status_t           status_next;

  // never stalls the command side
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // key taken as KEY_WIDTH signed bits of the value port
  assign new_key = KEY_WIDTH'(value);

  assign full  = (entry_count == CNT_W'(DEPTH));
  assign empty = (entry_count == '0);

  // shift controls for the whole row
  always_comb begin
    op.enq = accept && (sipq_pkg::cmd_t'(cmd) == sipq_pkg::CMD_ENQ) && !full;
    op.deq = accept && (sipq_pkg::cmd_t'(cmd) == sipq_pkg::CMD_DEQ) && !empty;
  end

  // the cell row: each cell takes its left neighbour on an insert shift and its
  // right neighbour on a dequeue
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                        occupied;
    logic signed [KEY_WIDTH-1:0] left_key;
    logic                        left_greater;
    logic signed [KEY_WIDTH-1:0] right_key;

    assign occupied = (entry_count > CNT_W'(i));

    if (i == 0) begin : g_head
      assign left_key     = new_key;
      assign left_greater = 1'b0;
    end else begin : g_body
      assign left_key     = cell_key[i-1];
      assign left_greater = greater[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_key = cell_key[i];
    end else begin : g_inner
      assign right_key = cell_key[i+1];
    end

    sipq_cell #(
      .KEY_WIDTH (KEY_WIDTH)
    ) u_cell (
      .clk          (clk),
      .op           (op),
      .occupied     (occupied),
      .new_key      (new_key),
      .left_key     (left_key),
      .left_greater (left_greater),
      .right_key    (right_key),
      .greater      (greater[i]),
      .key          (cell_key[i])
    );
  end

  // result of the transaction being taken
  always_comb begin
    entry_count_next = entry_count;
    out_value_next   = '0;
    status_next      = sipq_pkg::ST_OK;
    if (accept) begin
      unique case (sipq_pkg::cmd_t'(cmd))
        sipq_pkg::CMD_ENQ: begin
          if (full) begin
            status_next = sipq_pkg::ST_OVERFLOW;
          end else begin
            entry_count_next = entry_count + CNT_W'(1);
          end
        end
        sipq_pkg::CMD_DEQ: begin
          if (empty) begin
            status_next    = sipq_pkg::ST_UNDERFLOW;
            out_value_next = sipq_pkg::UNDERFLOW_VALUE;
          end else begin
            out_value_next   = sipq_pkg::VALUE_W'(cell_key[0]);
            entry_count_next = entry_count - CNT_W'(1);
          end
        end
        default: begin
          status_next = sipq_pkg::ST_OK;
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      done        <= 1'b0;
    end else begin
      entry_count <= entry_count_next;
      done        <= accept;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      out_value <= out_value_next;
      status    <= status_next;
      count     <= sipq_pkg::COUNT_W'(entry_count_next);
    end
  end

  // every taken command gives a result strobe in the next cycle
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("result strobe missing after a command");

  // overflow only reported with the queue full
  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    (done && status == sipq_pkg::ST_OVERFLOW) |->
      (count == sipq_pkg::COUNT_W'(DEPTH)))
    else $error("overflow reported while not full");

  // underflow only on an empty queue, with the marker value
  a_underflow_empty: assert property (@(posedge clk) disable iff (rst)
    (done && status == sipq_pkg::ST_UNDERFLOW) |->
      (count == '0 && out_value == sipq_pkg::UNDERFLOW_VALUE))
    else $error("underflow result inconsistent");

  // the head of the row is the smallest key
  a_head_sorted: assert property (@(posedge clk) disable iff (rst)
    (entry_count >= CNT_W'(2)) |-> (cell_key[0] <= cell_key[1]))
    else $error("head cells out of order");

endmodule

FILE: tb/tb_top.sv
// self-checking testbench of the sorted-insertion min priority queue
`timescale 1ns / 100ps

module tb_top;

  localparam int QDEPTH = sipq_pkg::DEPTH_DEFAULT;

  // one result of the queue as the checker sees it
  typedef struct packed {
    logic [sipq_pkg::VALUE_W-1:0] key;
    sipq_pkg::status_t            status;
    logic [sipq_pkg::COUNT_W-1:0] count;
  } queue_result_t;

  // one row of the directed table; want is only used where typed is set
  typedef struct packed {
    sipq_pkg::cmd_t               op;
    logic [sipq_pkg::VALUE_W-1:0] key;
    bit                           typed;
    queue_result_t                want;
  } stim_row_t;

  logic                                clk = 1'b0;
  logic                                rst;
  logic                                start;
  logic                                busy;
  logic                                cmd;
  logic signed [sipq_pkg::VALUE_W-1:0] value;
  logic                                done;
  logic signed [sipq_pkg::VALUE_W-1:0] out_value;
  logic [1:0]                          status;
  logic [sipq_pkg::COUNT_W-1:0]        count;

  // side band travelling with each transaction: a typed-in expectation
  bit                                  typed_valid;
  queue_result_t                       typed_result;

  // model of the queue contents, kept in ascending order
  logic signed [sipq_pkg::VALUE_W-1:0] sorted_keys [QDEPTH];
  int                                  stored;

  // results still to come out of the block, oldest first
  queue_result_t                       pending_results [$];
  stim_row_t                           directed_rows [$];
  int                                  mismatch_count;

  sorted_insert_min_priority_queue i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .value     (value),
    .done      (done),
    .out_value (out_value),
    .status    (status),
    .count     (count)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // apply one command to the queue model and return the result it gives
  function automatic queue_result_t apply_command(sipq_pkg::cmd_t op,
                                                  logic signed [sipq_pkg::VALUE_W-1:0] key);
    queue_result_t res;
    int            pos;
    res.key    = '0;
    res.status = sipq_pkg::ST_OK;
    if (op == sipq_pkg::CMD_ENQ) begin
      if (stored >= QDEPTH) begin
        // full: key dropped, contents untouched
        res.status = sipq_pkg::ST_OVERFLOW;
      end else begin
        // walk down past every larger key, so equal keys keep arrival order
        pos = stored;
        while (pos > 0 && sorted_keys[pos-1] > key) begin
          sorted_keys[pos] = sorted_keys[pos-1];
          pos--;
        end
        sorted_keys[pos] = key;
        stored++;
      end
    end else if (stored == 0) begin
      // empty: nothing removed
      res.key    = sipq_pkg::UNDERFLOW_VALUE;
      res.status = sipq_pkg::ST_UNDERFLOW;
    end else begin
      // head leaves, the rest move up one place
      res.key = sorted_keys[0];
      for (int i = 1; i < stored; i++) sorted_keys[i-1] = sorted_keys[i];
      stored--;
    end
    res.count = sipq_pkg::COUNT_W'(stored);
    return res;
  endfunction

  // keys: mostly anywhere, with a good share of small values for ties and of extremes
  function automatic logic [sipq_pkg::VALUE_W-1:0] draw_key();
    logic [sipq_pkg::VALUE_W-1:0] k;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: k = $urandom;
      4, 5, 6:    k = sipq_pkg::VALUE_W'($urandom_range(0, 8)) - sipq_pkg::VALUE_W'(4);
      7:          k = {1'b0, {(sipq_pkg::VALUE_W-1){1'b1}}};
      8:          k = {1'b1, {(sipq_pkg::VALUE_W-1){1'b0}}};
      default:    k = {$urandom_range(0, 1) ? 1'b1 : 1'b0,
                       {(sipq_pkg::VALUE_W-9){1'b0}}, 8'($urandom)};
    endcase
    return k;
  endfunction

  // table row helper
  function automatic void add_row(sipq_pkg::cmd_t op, logic [sipq_pkg::VALUE_W-1:0] key,
                                  bit typed, logic [sipq_pkg::VALUE_W-1:0] want_key,
                                  sipq_pkg::status_t want_status, int want_count);
    stim_row_t row;
    row.op           = op;
    row.key          = key;
    row.typed        = typed;
    row.want.key     = want_key;
    row.want.status  = want_status;
    row.want.count   = sipq_pkg::COUNT_W'(want_count);
    directed_rows.push_back(row);
  endfunction

  // the sender holds start low for a random number of cycles
  task automatic idle_gap(int pct);
    while ($urandom_range(0, 99) < pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // present one transaction and return at the edge that takes it
  task automatic issue(sipq_pkg::cmd_t op, logic [sipq_pkg::VALUE_W-1:0] key, bit typed,
                       queue_result_t want);
    start        <= 1'b1;
    cmd          <= op;
    value        <= key;
    typed_valid  <= typed;
    typed_result <= want;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  // checker: results are matched against the oldest pending one, and each
  // accepted transaction is run through the queue model
  always @(posedge clk) begin
    queue_result_t exp_res;
    queue_result_t model_res;
    if (rst === 1'b0) begin
      if (done === 1'b1) begin
        if (pending_results.size() == 0) begin
          $error("result with nothing pending: out_value %0d status %0d count %0d",
                 out_value, status, count);
          mismatch_count++;
        end else begin
          exp_res = pending_results.pop_front();
          if (out_value !== exp_res.key) begin
            $error("out_value: expected %0d, got %0d", $signed(exp_res.key), out_value);
            mismatch_count++;
          end
          if (status !== exp_res.status) begin
            $error("status: expected %0d, got %0d", exp_res.status, status);
            mismatch_count++;
          end
          if (count !== exp_res.count) begin
            $error("count: expected %0d, got %0d", exp_res.count, count);
            mismatch_count++;
          end
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        // the model always advances, even where the row carries its own answer
        model_res = apply_command(sipq_pkg::cmd_t'(cmd), value);
        pending_results.push_back(typed_valid ? typed_result : model_res);
      end
    end
  end

  // stimulus
  initial begin
    queue_result_t  none;
    stim_row_t      row;
    sipq_pkg::cmd_t op;
    int             idle_pct;
    int             left;
    int             run_len;
    int             enq_pct;
    int             drain_cycles;

    none           = '0;
    mismatch_count = 0;
    stored         = 0;
    rst          <= 1'b1;
    start        <= 1'b0;
    cmd          <= sipq_pkg::CMD_ENQ;
    value        <= '0;
    typed_valid  <= 1'b0;
    typed_result <= '0;

    // directed table: underflow from reset, both extremes, ties, fill to full,
    // overflow, then drain from the head
    add_row(sipq_pkg::CMD_DEQ, 32'hDEAD_BEEF, 1, sipq_pkg::UNDERFLOW_VALUE,
            sipq_pkg::ST_UNDERFLOW, 0);
    add_row(sipq_pkg::CMD_ENQ, 32'h7FFF_FFFF, 1, '0, sipq_pkg::ST_OK, 1);
    add_row(sipq_pkg::CMD_ENQ, 32'h8000_0000, 1, '0, sipq_pkg::ST_OK, 2);
    add_row(sipq_pkg::CMD_ENQ, 32'h0000_0000, 0, '0, sipq_pkg::ST_OK, 0);
    add_row(sipq_pkg::CMD_ENQ, 32'hFFFF_FFFF, 0, '0, sipq_pkg::ST_OK, 0);
    add_row(sipq_pkg::CMD_ENQ, 32'h0000_0005, 0, '0, sipq_pkg::ST_OK, 0);
    add_row(sipq_pkg::CMD_ENQ, 32'h0000_0005, 0, '0, sipq_pkg::ST_OK, 0);
    add_row(sipq_pkg::CMD_ENQ, 32'hFFFF_FFFB, 0, '0, sipq_pkg::ST_OK, 0);
    add_row(sipq_pkg::CMD_ENQ, 32'h7FFF_FFFF, 0, '0, sipq_pkg::ST_OK, 0);
    add_row(sipq_pkg::CMD_ENQ, 32'h8000_0000, 0, '0, sipq_pkg::ST_OK, 0);
    add_row(sipq_pkg::CMD_ENQ, 32'h0000_0003, 0, '0, sipq_pkg::ST_OK, 0);
    add_row(sipq_pkg::CMD_ENQ, 32'h0001_0000, 0, '0, sipq_pkg::ST_OK, 0);
    add_row(sipq_pkg::CMD_ENQ, 32'hFFFF_0000, 0, '0, sipq_pkg::ST_OK, 0);
    add_row(sipq_pkg::CMD_ENQ, 32'h0000_0001, 0, '0, sipq_pkg::ST_OK, 0);
    add_row(sipq_pkg::CMD_ENQ, 32'h0000_0002, 0, '0, sipq_pkg::ST_OK, 0);
    add_row(sipq_pkg::CMD_ENQ, 32'h5555_5555, 0, '0, sipq_pkg::ST_OK, 0);
    add_row(sipq_pkg::CMD_ENQ, 32'hAAAA_AAAA, 1, '0, sipq_pkg::ST_OK, 16);
    add_row(sipq_pkg::CMD_ENQ, 32'h0000_0007, 1, '0, sipq_pkg::ST_OVERFLOW, 16);
    add_row(sipq_pkg::CMD_DEQ, 32'h1234_5678, 1, 32'h8000_0000, sipq_pkg::ST_OK, 15);
    repeat (6) add_row(sipq_pkg::CMD_DEQ, 32'h0000_0000, 0, '0, sipq_pkg::ST_OK, 0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      issue(row.op, row.key, row.typed, row.want);
    end

    // random part: bursts with a varying enqueue share so the queue swings between
    // empty and full; sender idling differs per phase
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 15 : (ph == 1) ? 74 : 0;
      left     = 350;
      while (left > 0) begin
        run_len = $urandom_range(4, 40);
        case ($urandom_range(0, 2))
          0:       enq_pct = 15;
          1:       enq_pct = 50;
          default: enq_pct = 85;
        endcase
        for (int k = 0; k < run_len && left > 0; k++) begin
          op = ($urandom_range(0, 99) < enq_pct) ? sipq_pkg::CMD_ENQ : sipq_pkg::CMD_DEQ;
          idle_gap(idle_pct);
          issue(op, draw_key(), 0, none);
          left--;
        end
      end
    end
    start <= 1'b0;

    // wait for the last results, bounded
    drain_cycles = 0;
    while (pending_results.size() != 0 && drain_cycles < 50) begin
      @(posedge clk);
      drain_cycles++;
    end
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      mismatch_count++;
    end
    repeat (4) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
